FILE: hw/rtl/htb_pkg.sv
// Shared constants, codes and control types of the Huffman tree builder.
// Used by the controller, the datapath and the top level.
package htb_pkg;

  // Table geometry: leaves 0..255, internal nodes 256..510.
  localparam int NODE_SLOTS     = 511;
  localparam int LEAF_COUNT     = 256;
  localparam int IDX_W          = 9;
  localparam int NEWLINE_BYTE   = 10;
  localparam int COUNT_BITS_DEF = 32;

  // Configuration register map.
  localparam int          PADDR_W       = 3;
  localparam logic [2:0]  CFG_ADDR_DROP = 3'd0;

  // Input actions.
  typedef enum logic [1:0] {
    ACT_CLEAR = 2'd0,
    ACT_COUNT = 2'd1,
    ACT_BUILD = 2'd2,
    ACT_READ  = 2'd3
  } action_e;

  // Per-cycle datapath operations issued by the controller.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_CLR,
    OP_CNT_WR,
    OP_OUT_READ,
    OP_BCLR,
    OP_LEAF_RD,
    OP_LEAF_WR,
    OP_SCAN_INIT,
    OP_SCAN,
    OP_TAKE_A,
    OP_TAKE_B,
    OP_MAKE,
    OP_OUT_BUILD
  } dp_op_e;

  typedef struct packed {
    dp_op_e      op;
    logic [1:0]  action;
  } cmd_t;

  typedef struct packed {
    logic k_last;
    logic leaf_last;
    logic scan_done;
    logic i_last;
    logic out_free;
  } status_t;

endpackage

FILE: hw/rtl/htb_if.sv
// Valid/ready channel interfaces for the Huffman tree builder.
// Depends on nothing but the field widths of the block.
interface htb_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] byte_value;
  logic [8:0] node_index;

  modport source (output valid, action, byte_value, node_index, input ready);
  modport sink   (input valid, action, byte_value, node_index, output ready);
endinterface

interface htb_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] weight;
  logic [8:0]  right_child;
  logic [8:0]  left_child;
  logic        has_children;
  logic        still_active;
  logic [8:0]  root_node;
  logic        root_found;

  modport source (output valid, weight, right_child, left_child, has_children,
                  still_active, root_node, root_found, input ready);
  modport sink   (input valid, weight, right_child, left_child, has_children,
                  still_active, root_node, root_found, output ready);
endinterface

FILE: hw/rtl/htb_ctrl.sv
// Controller state machine of the Huffman tree builder.
// Depends on htb_pkg; drives the datapath through cmd_t and reads status_t.
module htb_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [1:0]        in_action_i,
  output logic              in_ready_o,
  input  htb_pkg::status_t  st_i,
  output htb_pkg::cmd_t     cmd_o
);

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_CNT   = 4'd2;
  localparam logic [3:0] S_RDR   = 4'd3;
  localparam logic [3:0] S_BCLR  = 4'd4;
  localparam logic [3:0] S_LRD   = 4'd5;
  localparam logic [3:0] S_LWR   = 4'd6;
  localparam logic [3:0] S_INIT1 = 4'd7;
  localparam logic [3:0] S_SCAN1 = 4'd8;
  localparam logic [3:0] S_TAKE1 = 4'd9;
  localparam logic [3:0] S_INIT2 = 4'd10;
  localparam logic [3:0] S_SCAN2 = 4'd11;
  localparam logic [3:0] S_TAKE2 = 4'd12;
  localparam logic [3:0] S_MAKE  = 4'd13;
  localparam logic [3:0] S_BOUT  = 4'd14;

  logic [3:0] state_q, state_d;

  // Next state and the datapath operation for this cycle.
  always_comb begin
    state_d      = state_q;
    cmd_o.op     = htb_pkg::OP_NONE;
    cmd_o.action = in_action_i;
    in_ready_o   = 1'b0;
    case (state_q)
      S_CLR: begin
        cmd_o.op = htb_pkg::OP_CLR;
        if (st_i.k_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = htb_pkg::OP_ACCEPT;
          case (in_action_i)
            htb_pkg::ACT_CLEAR: state_d = S_CLR;
            htb_pkg::ACT_COUNT: state_d = S_CNT;
            htb_pkg::ACT_BUILD: state_d = S_BCLR;
            default:            state_d = S_RDR;
          endcase
        end
      end
      S_CNT: begin
        cmd_o.op = htb_pkg::OP_CNT_WR;
        state_d  = S_IDLE;
      end
      S_RDR: begin
        if (st_i.out_free) begin
          cmd_o.op = htb_pkg::OP_OUT_READ;
          state_d  = S_IDLE;
        end
      end
      S_BCLR: begin
        cmd_o.op = htb_pkg::OP_BCLR;
        if (st_i.k_last) state_d = S_LRD;
      end
      S_LRD: begin
        cmd_o.op = htb_pkg::OP_LEAF_RD;
        state_d  = S_LWR;
      end
      S_LWR: begin
        cmd_o.op = htb_pkg::OP_LEAF_WR;
        state_d  = st_i.leaf_last ? S_INIT1 : S_LRD;
      end
      S_INIT1: begin
        cmd_o.op = htb_pkg::OP_SCAN_INIT;
        state_d  = S_SCAN1;
      end
      S_SCAN1: begin
        cmd_o.op = htb_pkg::OP_SCAN;
        if (st_i.scan_done) state_d = S_TAKE1;
      end
      S_TAKE1: begin
        cmd_o.op = htb_pkg::OP_TAKE_A;
        state_d  = S_INIT2;
      end
      S_INIT2: begin
        cmd_o.op = htb_pkg::OP_SCAN_INIT;
        state_d  = S_SCAN2;
      end
      S_SCAN2: begin
        cmd_o.op = htb_pkg::OP_SCAN;
        if (st_i.scan_done) state_d = S_TAKE2;
      end
      S_TAKE2: begin
        cmd_o.op = htb_pkg::OP_TAKE_B;
        state_d  = S_MAKE;
      end
      S_MAKE: begin
        cmd_o.op = htb_pkg::OP_MAKE;
        state_d  = st_i.i_last ? S_BOUT : S_INIT1;
      end
      S_BOUT: begin
        if (st_i.out_free) begin
          cmd_o.op = htb_pkg::OP_OUT_BUILD;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Reset starts with a sweep that zeroes the node table.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: hw/rtl/htb_datapath.sv
// Datapath of the Huffman tree builder: node table memory, scan registers,
// counters and the output register. Depends on htb_pkg.
module htb_datapath #(
  parameter int COUNT_BITS = htb_pkg::COUNT_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  htb_pkg::cmd_t     cmd_i,
  output htb_pkg::status_t  st_o,
  input  logic [7:0]        byte_value_i,
  input  logic [8:0]        node_index_i,
  input  logic              drop_nl_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic [31:0]       weight_o,
  output logic [8:0]        right_child_o,
  output logic [8:0]        left_child_o,
  output logic              has_children_o,
  output logic              still_active_o,
  output logic [8:0]        root_node_o,
  output logic              root_found_o
);

  localparam int IDX_W = htb_pkg::IDX_W;
  localparam int ENT_W = COUNT_BITS + 2 + 2 * IDX_W;
  localparam int R_LO  = IDX_W;
  localparam int INT_B = 2 * IDX_W;
  localparam int ACT_B = 2 * IDX_W + 1;
  localparam int W_LO  = 2 * IDX_W + 2;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // Node table: {weight, active, internal, right, left} per entry.
  logic [ENT_W-1:0] mem_q [htb_pkg::NODE_SLOTS];
  logic [ENT_W-1:0] rdata_q;
  logic             re, we;
  logic [IDX_W-1:0] ra, wa;
  logic [ENT_W-1:0] wd;

  logic [IDX_W-1:0]      k_q, i_q, pidx_q, pick_idx_q, a_idx_q, b_idx_q, root_q;
  logic                  pend_q, pick_v_q, a_v_q, b_v_q, found_q, oor_q;
  logic [COUNT_BITS-1:0] best_q, a_w_q, b_w_q;
  logic [ENT_W-1:0]      pick_ent_q;
  logic [7:0]            byte_q;
  logic                  out_valid_q;

  logic [COUNT_BITS-1:0] rd_w, cnt_w, leaf_w, sum_w;
  logic [COUNT_BITS:0]   sum_full;
  logic                  rd_act, rd_int, is_nl;
  logic [63:0]           rd_w_ext;

  assign rd_w   = rdata_q[ENT_W-1:W_LO];
  assign rd_act = rdata_q[ACT_B];
  assign rd_int = rdata_q[INT_B];

  // Saturating increment for counting and newline removal for the leaf pass.
  assign cnt_w  = (rd_w == COUNT_MAX) ? rd_w : rd_w + 1'b1;
  assign is_nl  = (k_q == IDX_W'(htb_pkg::NEWLINE_BYTE)) && drop_nl_i;
  assign leaf_w = (is_nl && (rd_w != '0)) ? rd_w - 1'b1 : rd_w;

  // Saturating sum of the two children.
  assign sum_full = {1'b0, a_w_q} + {1'b0, b_w_q};
  assign sum_w    = sum_full[COUNT_BITS] ? COUNT_MAX : sum_full[COUNT_BITS-1:0];
  assign rd_w_ext = 64'(rd_w);

  // Status back to the controller.
  assign st_o.k_last    = (k_q == IDX_W'(htb_pkg::NODE_SLOTS - 1));
  assign st_o.leaf_last = (k_q == IDX_W'(htb_pkg::LEAF_COUNT - 1));
  assign st_o.scan_done = (k_q == i_q) && !pend_q;
  assign st_o.i_last    = (i_q == IDX_W'(htb_pkg::NODE_SLOTS - 1));
  assign st_o.out_free  = !out_valid_q || out_ready_i;
  assign out_valid_o    = out_valid_q;

  // Memory port addressing per operation.
  always_comb begin
    re = 1'b0;
    ra = k_q;
    we = 1'b0;
    wa = k_q;
    wd = '0;
    case (cmd_i.op)
      htb_pkg::OP_ACCEPT: begin
        re = (cmd_i.action == htb_pkg::ACT_COUNT) || (cmd_i.action == htb_pkg::ACT_READ);
        if (cmd_i.action == htb_pkg::ACT_COUNT) begin
          ra = {1'b0, byte_value_i};
        end else if (node_index_i == IDX_W'(htb_pkg::NODE_SLOTS)) begin
          ra = '0;
        end else begin
          ra = node_index_i;
        end
      end
      htb_pkg::OP_CLR, htb_pkg::OP_BCLR: begin
        we = 1'b1;
      end
      htb_pkg::OP_CNT_WR: begin
        we = 1'b1;
        wa = {1'b0, byte_q};
        wd = {cnt_w, rdata_q[W_LO-1:0]};
      end
      htb_pkg::OP_LEAF_RD: begin
        re = 1'b1;
      end
      htb_pkg::OP_LEAF_WR: begin
        we = 1'b1;
        wd = {leaf_w, (leaf_w != '0), rd_int, rdata_q[INT_B-1:0]};
      end
      htb_pkg::OP_SCAN: begin
        re = (k_q != i_q);
      end
      htb_pkg::OP_TAKE_A, htb_pkg::OP_TAKE_B: begin
        we = pick_v_q;
        wa = pick_idx_q;
        wd = pick_ent_q & ~(ENT_W'(1) << ACT_B);
      end
      htb_pkg::OP_MAKE: begin
        we = a_v_q && b_v_q;
        wa = i_q;
        wd = {sum_w, 1'b1, 1'b1, a_idx_q, b_idx_q};
      end
      default: ;
    endcase
  end

  // Node table with registered read data.
  always_ff @(posedge clk_i) begin
    if (we) mem_q[wa] <= wd;
    if (re) rdata_q <= mem_q[ra];
  end

  // Counters, scan state and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q            <= '0;
      i_q            <= '0;
      pidx_q         <= '0;
      pick_idx_q     <= '0;
      a_idx_q        <= '0;
      b_idx_q        <= '0;
      root_q         <= '0;
      pend_q         <= 1'b0;
      pick_v_q       <= 1'b0;
      a_v_q          <= 1'b0;
      b_v_q          <= 1'b0;
      found_q        <= 1'b0;
      oor_q          <= 1'b0;
      best_q         <= '0;
      a_w_q          <= '0;
      b_w_q          <= '0;
      pick_ent_q     <= '0;
      byte_q         <= '0;
      out_valid_q    <= 1'b0;
      weight_o       <= '0;
      right_child_o  <= '0;
      left_child_o   <= '0;
      has_children_o <= 1'b0;
      still_active_o <= 1'b0;
      root_node_o    <= '0;
      root_found_o   <= 1'b0;
    end else begin
      // A taken result is dropped unless a new one is loaded in the same cycle.
      if (out_ready_i && (cmd_i.op != htb_pkg::OP_OUT_READ) &&
          (cmd_i.op != htb_pkg::OP_OUT_BUILD)) begin
        out_valid_q <= 1'b0;
      end
      case (cmd_i.op)
        htb_pkg::OP_ACCEPT: begin
          byte_q  <= byte_value_i;
          oor_q   <= (node_index_i == IDX_W'(htb_pkg::NODE_SLOTS));
          k_q     <= (cmd_i.action == htb_pkg::ACT_BUILD) ?
                     IDX_W'(htb_pkg::LEAF_COUNT) : '0;
          root_q  <= '0;
          found_q <= 1'b0;
        end
        htb_pkg::OP_CLR, htb_pkg::OP_BCLR: begin
          k_q <= st_o.k_last ? '0 : k_q + 1'b1;
        end
        htb_pkg::OP_LEAF_WR: begin
          if (st_o.leaf_last) begin
            k_q <= '0;
            i_q <= IDX_W'(htb_pkg::LEAF_COUNT);
          end else begin
            k_q <= k_q + 1'b1;
          end
        end
        htb_pkg::OP_SCAN_INIT: begin
          k_q      <= '0;
          pend_q   <= 1'b0;
          pick_v_q <= 1'b0;
          best_q   <= COUNT_MAX;
        end
        htb_pkg::OP_SCAN: begin
          // Ties go to the later index, so the compare is less-or-equal.
          if (pend_q && rd_act && (rd_w <= best_q)) begin
            best_q     <= rd_w;
            pick_idx_q <= pidx_q;
            pick_ent_q <= rdata_q;
            pick_v_q   <= 1'b1;
          end
          if (k_q != i_q) begin
            pend_q <= 1'b1;
            pidx_q <= k_q;
            k_q    <= k_q + 1'b1;
          end else begin
            pend_q <= 1'b0;
          end
        end
        htb_pkg::OP_TAKE_A: begin
          a_v_q   <= pick_v_q;
          a_idx_q <= pick_idx_q;
          a_w_q   <= best_q;
        end
        htb_pkg::OP_TAKE_B: begin
          b_v_q   <= pick_v_q;
          b_idx_q <= pick_idx_q;
          b_w_q   <= best_q;
        end
        htb_pkg::OP_MAKE: begin
          if (a_v_q && b_v_q) begin
            root_q  <= i_q;
            found_q <= 1'b1;
          end
          if (!st_o.i_last) i_q <= i_q + 1'b1;
        end
        htb_pkg::OP_OUT_READ: begin
          out_valid_q    <= 1'b1;
          weight_o       <= oor_q ? '0 : rd_w_ext[31:0];
          right_child_o  <= (!oor_q && rd_int) ? rdata_q[INT_B-1:R_LO] : '0;
          left_child_o   <= (!oor_q && rd_int) ? rdata_q[R_LO-1:0] : '0;
          has_children_o <= !oor_q && rd_int;
          still_active_o <= !oor_q && rd_act;
          root_node_o    <= '0;
          root_found_o   <= 1'b0;
        end
        htb_pkg::OP_OUT_BUILD: begin
          out_valid_q    <= 1'b1;
          weight_o       <= '0;
          right_child_o  <= '0;
          left_child_o   <= '0;
          has_children_o <= 1'b0;
          still_active_o <= 1'b0;
          root_node_o    <= root_q;
          root_found_o   <= found_q;
        end
        default: ;
      endcase
    end
  end

endmodule

FILE: hw/rtl/huffman_tree_builder.sv
// Huffman tree builder: the time of a build is set by the sequential min scans over the
// node table. After reset the block sweeps the 511-entry table to zero with ready low;
// configuration writes are taken at all times.
module huffman_tree_builder #(
  parameter int COUNT_BITS = htb_pkg::COUNT_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  htb_in_if.sink                       in_i,
  htb_out_if.source                    out_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [htb_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  htb_pkg::cmd_t    cmd;
  htb_pkg::status_t st;
  logic             drop_nl_q;

  // Configuration register; writes complete in the access cycle.
  assign pready = 1'b1;
  assign prdata = (paddr == htb_pkg::CFG_ADDR_DROP) ? {31'b0, drop_nl_q} : 32'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drop_nl_q <= 1'b1;
    end else if (psel && penable && pwrite && (paddr == htb_pkg::CFG_ADDR_DROP)) begin
      drop_nl_q <= pwdata[0];
    end
  end

  htb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_action_i (in_i.action),
    .in_ready_o  (in_i.ready),
    .st_i        (st),
    .cmd_o       (cmd)
  );

  htb_datapath #(
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .st_o           (st),
    .byte_value_i   (in_i.byte_value),
    .node_index_i   (in_i.node_index),
    .drop_nl_i      (drop_nl_q),
    .out_ready_i    (out_o.ready),
    .out_valid_o    (out_o.valid),
    .weight_o       (out_o.weight),
    .right_child_o  (out_o.right_child),
    .left_child_o   (out_o.left_child),
    .has_children_o (out_o.has_children),
    .still_active_o (out_o.still_active),
    .root_node_o    (out_o.root_node),
    .root_found_o   (out_o.root_found)
  );

endmodule

FILE: hw/rtl/htb_checker.sv
// Port-level checks of the Huffman tree builder, bound to the top level.
// Depends on htb_pkg for the action codes.
module htb_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  in_action,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] weight,
  input logic        has_children,
  input logic        still_active,
  input logic        root_found
);

  // A result waiting for the sink stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> $stable(weight) && $stable(root_found))
    else $error("result payload changed while stalled");

  // A count transaction needs its write cycle before the next one.
  a_count_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready && (in_action == htb_pkg::ACT_COUNT) |=> !in_ready)
    else $error("ready high right after a count");

  // Build results carry only root fields; read results never report a root.
  a_result_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && root_found |-> !has_children && !still_active && (weight == 32'b0))
    else $error("mixed build and read fields");

endmodule

bind huffman_tree_builder htb_checker u_htb_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid     (in_i.valid),
  .in_ready     (in_i.ready),
  .in_action    (in_i.action),
  .out_valid    (out_o.valid),
  .out_ready    (out_o.ready),
  .weight       (out_o.weight),
  .has_children (out_o.has_children),
  .still_active (out_o.still_active),
  .root_found   (out_o.root_found)
);

FILE: test/htb_scoreboard.sv
// Scoreboard for the Huffman tree builder: a predictor of the node table and a queue of
// expected results. Depends on htb_pkg for the action codes and table geometry.
`timescale 1ns / 1ps

package htb_scoreboard_pkg;

  typedef struct packed {
    logic [31:0] weight;
    logic [8:0]  right_child;
    logic [8:0]  left_child;
    logic        has_children;
    logic        still_active;
    logic [8:0]  root_node;
    logic        root_found;
  } node_result_t;

  localparam logic [31:0] WEIGHT_MAX = 32'hFFFF_FFFF;

  class htb_scoreboard;
    logic [31:0]  weight_tab [htb_pkg::NODE_SLOTS];
    logic         active_tab [htb_pkg::NODE_SLOTS];
    logic [8:0]   right_tab  [htb_pkg::NODE_SLOTS];
    logic [8:0]   left_tab   [htb_pkg::NODE_SLOTS];
    logic         inner_tab  [htb_pkg::NODE_SLOTS];
    logic         drop_newline;
    node_result_t expected_q[$];
    int           mismatches;

    function new();
      wipe_table();
      drop_newline = 1'b1;
      mismatches   = 0;
    endfunction

    function void wipe_table();
      for (int i = 0; i < htb_pkg::NODE_SLOTS; i++) begin
        weight_tab[i] = '0;
        active_tab[i] = 1'b0;
        right_tab[i]  = '0;
        left_tab[i]   = '0;
        inner_tab[i]  = 1'b0;
      end
    endfunction

    // Least active node below the bound, highest index on ties; -1 if none.
    function int pick_least(int bound);
      int          pick;
      logic [31:0] best;
      pick = -1;
      best = WEIGHT_MAX;
      for (int i = 0; i < bound; i++) begin
        if (active_tab[i] && weight_tab[i] <= best) begin
          best = weight_tab[i];
          pick = i;
        end
      end
      if (pick >= 0) active_tab[pick] = 1'b0;
      return pick;
    endfunction

    function node_result_t build_tree();
      node_result_t r;
      int           a;
      int           b;
      logic [32:0]  sum;
      r = '0;
      for (int i = htb_pkg::LEAF_COUNT; i < htb_pkg::NODE_SLOTS; i++) begin
        weight_tab[i] = '0;
        active_tab[i] = 1'b0;
        right_tab[i]  = '0;
        left_tab[i]   = '0;
        inner_tab[i]  = 1'b0;
      end
      if (drop_newline && weight_tab[htb_pkg::NEWLINE_BYTE] != 0)
        weight_tab[htb_pkg::NEWLINE_BYTE] = weight_tab[htb_pkg::NEWLINE_BYTE] - 1;
      for (int i = 0; i < htb_pkg::LEAF_COUNT; i++) active_tab[i] = (weight_tab[i] != 0);
      for (int i = htb_pkg::LEAF_COUNT; i < htb_pkg::NODE_SLOTS; i++) begin
        a = pick_least(i);
        b = pick_least(i);
        if (a >= 0 && b >= 0) begin
          sum = {1'b0, weight_tab[a]} + {1'b0, weight_tab[b]};
          weight_tab[i] = sum[32] ? WEIGHT_MAX : sum[31:0];
          right_tab[i]  = a[8:0];
          left_tab[i]   = b[8:0];
          active_tab[i] = 1'b1;
          inner_tab[i]  = 1'b1;
          r.root_node   = i[8:0];
          r.root_found  = 1'b1;
        end
      end
      return r;
    endfunction

    // Notes one accepted input transaction and queues the result it causes.
    function void note_input(htb_pkg::action_e act, logic [7:0] byte_v, logic [8:0] idx);
      node_result_t r;
      r = '0;
      case (act)
        htb_pkg::ACT_CLEAR: wipe_table();
        htb_pkg::ACT_COUNT: begin
          if (weight_tab[byte_v] != WEIGHT_MAX) weight_tab[byte_v] = weight_tab[byte_v] + 1;
        end
        htb_pkg::ACT_BUILD: expected_q.push_back(build_tree());
        default: begin
          if (idx < htb_pkg::NODE_SLOTS) begin
            r.weight = weight_tab[idx];
            if (inner_tab[idx]) begin
              r.right_child  = right_tab[idx];
              r.left_child   = left_tab[idx];
              r.has_children = 1'b1;
            end
            r.still_active = active_tab[idx];
          end
          expected_q.push_back(r);
        end
      endcase
    endfunction

    // Compares one accepted output transaction with the oldest expectation.
    function void check_result(node_result_t got);
      node_result_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
        return;
      end
      want = expected_q.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
      end
    endfunction
  endclass
endpackage

FILE: test/tb_huffman_tree_builder.sv
// Top level testbench of the Huffman tree builder: drives actions and APB writes, checks
// every result against the scoreboard. Depends on htb_pkg, htb_if and htb_scoreboard.
`timescale 1ns / 1ps

module tb_huffman_tree_builder;

  logic                         clk;
  logic                         rst_n;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [htb_pkg::PADDR_W-1:0]  paddr;
  logic [31:0]                  pwdata;
  logic [31:0]                  prdata;
  logic                         pready;
  logic                         quiet;

  htb_in_if  req_if ();
  htb_out_if res_if ();

  htb_scoreboard_pkg::htb_scoreboard tree_sb;

  huffman_tree_builder dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .in_i    (req_if.sink),
    .out_o   (res_if.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(12.0 * 6_000_000);
    $display("FAIL");
    $finish;
  end

  // Result side: random stall bursts, and a check on every transaction.
  int stall_left;
  always @(posedge clk) begin
    if (rst_n && res_if.valid && res_if.ready)
      tree_sb.check_result('{res_if.weight, res_if.right_child, res_if.left_child,
                             res_if.has_children, res_if.still_active,
                             res_if.root_node, res_if.root_found});
    if (!rst_n) begin
      stall_left   <= 0;
      res_if.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      res_if.ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(1, 6) - 1;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  // One input transaction, with an occasional idle burst ahead of it.
  task automatic send_item(htb_pkg::action_e act, logic [7:0] byte_v, logic [8:0] idx);
    int gap;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 6);
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid      <= 1'b1;
    req_if.action     <= act;
    req_if.byte_value <= byte_v;
    req_if.node_index <= idx;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    tree_sb.note_input(act, byte_v, idx);
  endtask

  task automatic release_valid();
    req_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Waits until no result is outstanding and a clear would have finished.
  task automatic wait_idle();
    release_valid();
    while (tree_sb.expected_q.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  task automatic write_drop_newline(logic value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= htb_pkg::CFG_ADDR_DROP;
    pwdata  <= {31'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    tree_sb.drop_newline = value;
    @(posedge clk);
  endtask

  task automatic random_counts(int n);
    logic [7:0] b;
    for (int k = 0; k < n; k++) begin
      // Skew toward a few bytes so that the tree has uneven weights and ties.
      b = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 7) * 37) : 8'($urandom);
      send_item(htb_pkg::ACT_COUNT, b, 9'($urandom));
    end
  endtask

  task automatic random_reads(int n);
    logic [8:0] idx;
    for (int k = 0; k < n; k++) begin
      idx = ($urandom_range(0, 1) == 0) ? 9'($urandom_range(256, 511))
                                        : 9'($urandom_range(0, 511));
      send_item(htb_pkg::ACT_READ, 8'($urandom), idx);
    end
  endtask

  initial begin
    tree_sb           = new();
    quiet             = 1'b0;
    rst_n             = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    req_if.valid      = 1'b0;
    req_if.action     = htb_pkg::ACT_CLEAR;
    req_if.byte_value = '0;
    req_if.node_index = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty table reads, then a lone leaf after the newline count is dropped.
    write_drop_newline(1'b1);
    send_item(htb_pkg::ACT_READ, 8'd0, 9'd0);
    send_item(htb_pkg::ACT_READ, 8'd255, 9'd510);
    send_item(htb_pkg::ACT_READ, 8'd0, 9'd511);
    send_item(htb_pkg::ACT_COUNT, 8'd10, 9'd0);
    send_item(htb_pkg::ACT_COUNT, 8'd200, 9'd511);
    send_item(htb_pkg::ACT_COUNT, 8'd0, 9'd0);
    send_item(htb_pkg::ACT_CLEAR, 8'd0, 9'd0);
    send_item(htb_pkg::ACT_COUNT, 8'd10, 9'd0);
    send_item(htb_pkg::ACT_COUNT, 8'd255, 9'd0);
    send_item(htb_pkg::ACT_BUILD, 8'd0, 9'd0);
    send_item(htb_pkg::ACT_READ, 8'd0, 9'd10);
    send_item(htb_pkg::ACT_READ, 8'd0, 9'd255);
    send_item(htb_pkg::ACT_READ, 8'd0, 9'd256);
    send_item(htb_pkg::ACT_READ, 8'd0, 9'd511);

    // Random tree with the newline kept.
    wait_idle();
    write_drop_newline(1'b0);
    send_item(htb_pkg::ACT_CLEAR, 8'd0, 9'd0);
    random_counts(250);
    send_item(htb_pkg::ACT_BUILD, 8'd0, 9'd0);
    random_reads(120);

    // Rebuild on the same counts plus one newline count, with the newline dropped.
    wait_idle();
    write_drop_newline(1'b1);
    send_item(htb_pkg::ACT_COUNT, 8'd10, 9'd0);
    send_item(htb_pkg::ACT_BUILD, 8'd0, 9'd0);
    random_reads(80);

    // Last part without idling on either side.
    wait_idle();
    quiet = 1'b1;
    send_item(htb_pkg::ACT_CLEAR, 8'd0, 9'd0);
    random_counts(150);
    send_item(htb_pkg::ACT_BUILD, 8'd0, 9'd0);
    random_reads(80);
    send_item(htb_pkg::ACT_CLEAR, 8'd0, 9'd0);
    send_item(htb_pkg::ACT_READ, 8'd0, 9'd300);
    release_valid();

    while (tree_sb.expected_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (tree_sb.mismatches == 0 && tree_sb.expected_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
